// ----- rtl/rational_arithmetic_unit_defines.svh -----
// Assertion macros for the rational arithmetic unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RAU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rstn, prop, msg)
`define RAU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/rau_pkg.sv -----
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_INT = 3'd4
    } func_t;

    // Classified job handed from the front end to the back end.
    typedef enum logic [1:0] {
        JOB_RAT = 2'd0,
        JOB_INT = 2'd1,
        JOB_ERR = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t    kind;
        logic         sub;
        logic         swap;   // divide: den uses b_num
        logic         mul;    // multiply: num is a_num*b_num
        logic [31:0]  a_num;
        logic [30:0]  a_den;
        logic [31:0]  b_num;
        logic [30:0]  b_den;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SETUP, ST_GCD_SHIFT, ST_GCD_ODD,
        ST_GCD_LOOP, ST_DIV_START, ST_DIV_RUN, ST_DIV_NEXT, ST_DONE
    } bstate_t;
endpackage
`default_nettype wire

// ----- rtl/rau_front.sv -----
// Front end: takes input beats, sign-adjusts operands and classifies the op.
// Depends on rau_pkg.
`default_nettype none
module rau_front import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [31:0] a_num,
    input  wire logic [30:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [30:0] b_den,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    job_t job_reg, job_next;
    logic valid_reg;

    function automatic logic [31:0] sext(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        for (int i = 0; i < 32; i++)
            if (i >= OPERAND_WIDTH) r[i] = v[OPERAND_WIDTH-1];
        return r;
    endfunction

    function automatic logic [30:0] dmask(input logic [30:0] v);
        logic [30:0] r;
        r = v;
        for (int i = 0; i < 31; i++)
            if (i >= OPERAND_WIDTH - 1) r[i] = 1'b0;
        return r;
    endfunction

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb begin
        job_next       = '0;
        job_next.a_num = sext(a_num);
        job_next.a_den = dmask(a_den);
        job_next.b_num = sext(b_num);
        job_next.b_den = dmask(b_den);
        job_next.kind  = JOB_RAT;
        case (func)
            FUNC_ADD: job_next.kind = JOB_RAT;
            FUNC_SUB: job_next.sub = 1'b1;
            FUNC_MUL: job_next.mul = 1'b1;
            FUNC_DIV: job_next.swap = 1'b1;
            FUNC_INT: job_next.kind = JOB_INT;
            default:  job_next.kind = JOB_ERR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) job_reg <= job_next;
    end
endmodule
`default_nettype wire

// ----- rtl/rau_queue.sv -----
// Two-entry queue between front and back end.
// Depends on rau_pkg.
`default_nettype none
module rau_queue import rau_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);
    `include "rational_arithmetic_unit_defines.svh"
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    `RAU_ASSERT(a_q_cnt, aclk, aresetn, cnt_reg != 2'd3, "queue count overflow")
    `RAU_ASSERT(a_q_ptr, aclk, aresetn, (cnt_reg == 2'd1) == (wp_reg != rp_reg), "queue ptr mismatch")
    `RAU_ASSERT(a_q_hold, aclk, aresetn, (rd_valid && !rd_ready && !$past(rd)) |=> rd_valid, "queue lost entry")
endmodule
`default_nettype wire

// ----- rtl/rau_back.sv -----
// Back end: cross products, binary GCD and restoring divides, one job at a time.
// Depends on rau_pkg.
`default_nettype none
module rau_back import rau_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              res_valid,
    input  wire logic         res_ready,
    output logic [63:0]       res_num,
    output logic [62:0]       res_den,
    output logic              res_err
);
    `include "rational_arithmetic_unit_defines.svh"
    bstate_t state_reg, state_next;
    job_t    job_reg;
    logic signed [63:0] p_reg;           // product register
    logic signed [63:0] n_reg;
    logic [63:0] nm_reg, dm_reg, x_reg, y_reg, g_reg;
    logic [63:0] q_reg, r_reg, dvd_reg;
    logic [6:0]  k_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg, second_reg;
    logic [63:0] out_num_reg;
    logic [62:0] out_den_reg;
    logic        out_err_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic [63:0] rsh;
    logic [63:0] pnm, pdm;
    logic        pneg;

    // One shared 33x33 signed multiplier.
    always_comb begin
        ma = 33'(signed'(job_reg.a_num));
        mb = 33'(signed'({1'b0, job_reg.b_den}));
        case (state_reg)
            ST_MUL1: begin
                ma = 33'(signed'(job_reg.a_num));
                mb = job_reg.mul ? 33'(signed'(job_reg.b_num))
                                 : 33'(signed'({1'b0, job_reg.b_den}));
            end
            ST_MUL2: begin
                ma = 33'(signed'(job_reg.b_num));
                mb = 33'(signed'({1'b0, job_reg.a_den}));
            end
            ST_MUL3: begin
                ma = 33'(signed'({1'b0, job_reg.a_den}));
                mb = job_reg.swap ? 33'(signed'(job_reg.b_num))
                                  : 33'(signed'({1'b0, job_reg.b_den}));
            end
            default: ;
        endcase
        prod = ma * mb;
    end

    always_comb begin
        pneg = n_reg[63] != p_reg[63];
        pnm  = n_reg[63] ? 64'(-n_reg) : 64'(n_reg);
        pdm  = p_reg[63] ? 64'(-p_reg) : 64'(p_reg);
        rsh  = {r_reg[62:0], dvd_reg[63]};
    end

    assign job_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res_num   = out_num_reg;
    assign res_den   = out_den_reg;
    assign res_err   = out_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job_valid) begin
                case (job.kind)
                    JOB_RAT: state_next = ST_MUL1;
                    JOB_INT: state_next = ST_DIV_START;
                    default: state_next = ST_DONE;
                endcase
            end
            // multiply and divide have a single numerator product
            ST_MUL1:  state_next = (job_reg.mul || job_reg.swap) ? ST_MUL3 : ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_SETUP;
            ST_SETUP: state_next = (p_reg == 0 || n_reg == 0) ? ST_DONE : ST_GCD_SHIFT;
            ST_GCD_SHIFT: if (x_reg[0] || y_reg[0]) state_next = ST_GCD_ODD;
            ST_GCD_ODD:   if (x_reg[0]) state_next = ST_GCD_LOOP;
            ST_GCD_LOOP:  if (y_reg == 0) state_next = ST_DIV_START;
            ST_DIV_START: state_next = (job_reg.kind == JOB_INT && job_reg.a_den == 0)
                                       ? ST_DONE : ST_DIV_RUN;
            ST_DIV_RUN:   if (cnt_reg == 7'd63) state_next = ST_DIV_NEXT;
            ST_DIV_NEXT:  state_next = (job_reg.kind == JOB_RAT && !second_reg)
                                       ? ST_DIV_START : ST_DONE;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (job_valid) begin
                job_reg    <= job;
                second_reg <= 1'b0;
                out_num_reg <= '0;
                out_den_reg <= '0;
                out_err_reg <= job.kind == JOB_ERR;
                if (job.kind == JOB_INT) begin
                    neg_reg <= job.a_num[31];
                    nm_reg  <= job.a_num[31] ? 64'(-signed'(64'(signed'(job.a_num))))
                                             : 64'(job.a_num);
                    g_reg   <= 64'(job.a_den);
                end
            end
            ST_MUL1: n_reg <= 64'(prod);
            ST_MUL2: n_reg <= job_reg.sub ? n_reg - 64'(prod) : n_reg + 64'(prod);
            ST_MUL3: p_reg <= 64'(prod);
            ST_SETUP: begin
                if (p_reg == 0) begin
                    out_err_reg <= 1'b1;
                end else if (n_reg == 0) begin
                    out_den_reg <= 63'(pdm);
                end
                neg_reg <= pneg;
                nm_reg  <= pnm;
                dm_reg  <= pdm;
                x_reg   <= pnm;
                y_reg   <= pdm;
                k_reg   <= '0;
            end
            ST_GCD_SHIFT: if (!(x_reg[0] || y_reg[0])) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 7'd1;
            end
            ST_GCD_ODD: if (!x_reg[0]) x_reg <= x_reg >> 1;
            ST_GCD_LOOP: begin
                if (y_reg == 0) begin
                    g_reg <= x_reg << k_reg[5:0];
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_reg <= y_reg;
                    y_reg <= x_reg - y_reg;
                end else begin
                    y_reg <= y_reg - x_reg;
                end
            end
            ST_DIV_START: begin
                dvd_reg <= second_reg ? dm_reg : nm_reg;
                r_reg   <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
                if (job_reg.kind == JOB_INT && job_reg.a_den == 0) out_err_reg <= 1'b1;
            end
            ST_DIV_RUN: begin
                cnt_reg <= cnt_reg + 7'd1;
                dvd_reg <= dvd_reg << 1;
                if (rsh >= g_reg) begin
                    r_reg <= rsh - g_reg;
                    q_reg <= {q_reg[62:0], 1'b1};
                end else begin
                    r_reg <= rsh;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
            end
            ST_DIV_NEXT: begin
                if (second_reg) begin
                    out_den_reg <= 63'(q_reg);
                end else begin
                    out_num_reg <= neg_reg ? 64'(-q_reg) : q_reg;
                    if (job_reg.kind == JOB_INT) out_den_reg <= 63'd1;
                end
                second_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    `RAU_ASSERT(a_b_err, aclk, aresetn, (res_valid && res_err) |-> (res_num == 0 && res_den == 0), "error result not zero")
    `RAU_ASSERT(a_b_hold, aclk, aresetn, (res_valid && !res_ready) |=> (res_valid && $stable(res_num)), "result dropped")
    `RAU_ASSERT(a_b_gcd, aclk, aresetn, (state_reg == ST_DIV_RUN) |-> (g_reg != 0), "zero divisor")
endmodule
`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: add, sub, mul, div of fractions with GCD reduction.
// Each item takes up to 3 multiply steps, a binary GCD and two 64-step restoring
// divides; the integer part takes one divide, and zero numerator or error results skip
// the GCD and the divides.
// One item in the back end at a time; a two-entry queue lets the front accept ahead.
// Reset: synchronous active-low aresetn clears all control state.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // func[2:0], a_num, a_den, b_num, b_den, pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // res_num[63:0], res_den[126:64], pad
    output logic              m_tuser    // err
);
    job_t fj, qj;
    logic fv, fr, qv, qr;
    logic [63:0] rn;
    logic [62:0] rd;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .func(s_tdata[2:0]), .a_num(s_tdata[34:3]), .a_den(s_tdata[65:35]),
        .b_num(s_tdata[97:66]), .b_den(s_tdata[128:98]),
        .job_valid(fv), .job_ready(fr), .job(fj));

    rau_queue u_queue (
        .aclk, .aresetn, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qj));

    rau_back u_back (
        .aclk, .aresetn, .job_valid(qv), .job_ready(qr), .job(qj),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_num(rn), .res_den(rd), .res_err(m_tuser));

    assign m_tdata = {1'b0, rd, rn};
endmodule
`default_nettype wire

// ----- sim/rational_arithmetic_unit_tb.sv -----
// Testbench for the rational arithmetic unit: streams fraction pairs with random
// operations and gaps, predicts each reduced result and compares it per beat.
// Depends on rau_pkg and rational_arithmetic_unit.
`default_nettype none
module rational_arithmetic_unit_tb;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        err;
    } fraction_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic m_tuser;

    logic [135:0] pending_beats[$];
    fraction_result_t expected_fractions[$];
    int s_gap = 0;
    int m_gap = 0;
    int errors = 0;
    longint cycle_count = 0;
    bit stim_done = 0;

    rational_arithmetic_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_result_t reduce_fraction(logic [135:0] beat);
        fraction_result_t r;
        logic [2:0] op;
        longint an, ad, bn, bd, n, d;
        logic [63:0] nm, dm, g;
        op = beat[2:0];
        an = longint'($signed(beat[34:3]));
        ad = longint'(beat[65:35]);
        bn = longint'($signed(beat[97:66]));
        bd = longint'(beat[128:98]);
        r = '{num: '0, den: '0, err: 1'b0};
        case (op)
            FUNC_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            FUNC_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            FUNC_MUL: begin n = an * bn; d = ad * bd; end
            FUNC_DIV: begin n = an * bd; d = ad * bn; end
            FUNC_INT: begin
                if (ad == 0) r.err = 1'b1;
                else begin
                    r.num = 64'(an / ad);
                    r.den = 63'd1;
                end
                return r;
            end
            default: begin
                r.err = 1'b1;
                return r;
            end
        endcase
        if (d == 0) r.err = 1'b1;
        else if (n == 0) r.den = 63'(abs64(d));
        else begin
            nm = abs64(n);
            dm = abs64(d);
            g = gcd64(nm, dm);
            nm = nm / g;
            r.num = ((n < 0) != (d < 0)) ? -nm : nm;
            r.den = 63'(dm / g);
        end
        return r;
    endfunction

    function automatic logic [135:0] pack_beat(logic [2:0] op, logic [31:0] an,
                                               logic [30:0] ad, logic [31:0] bn,
                                               logic [30:0] bd);
        return {7'b0, bd, bn, ad, an, op};
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 31'h7fff_ffff;
            1: return 31'($urandom_range(1, 12));
            2: return 31'($urandom_range(1, 5000));
            3: return 31'($urandom_range(0, 1)); // zero denominator now and then
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        return $urandom_range(1, 4);
    endfunction

    // driver: hold the beat until accepted, then advance after a gap
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_fractions.push_back(reduce_fraction(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_tvalid <= 1'b0;
                    s_gap <= s_gap - 1;
                end else if (pending_beats.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_beats.pop_front();
                    s_gap <= rand_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        fraction_result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_fractions.size() == 0) begin
                    $display("%0t: unexpected result num=%h den=%h err=%b", $time,
                             m_tdata[63:0], m_tdata[126:64], m_tuser);
                    errors <= errors + 1;
                end else begin
                    e = expected_fractions.pop_front();
                    if (m_tdata[63:0] !== e.num || m_tdata[126:64] !== e.den
                            || m_tuser !== e.err) begin
                        $display("%0t: mismatch expected num=%h den=%h err=%b actual num=%h den=%h err=%b",
                                 $time, e.num, e.den, e.err,
                                 m_tdata[63:0], m_tdata[126:64], m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            if (m_gap > 0) begin
                m_tready <= 1'b0;
                m_gap <= m_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) m_gap <= rand_gap();
            end
        end
    end

    initial begin
        logic [2:0] op;
        for (int f = 0; f <= 7; f++) begin
            pending_beats.push_back(pack_beat(3'(f), 32'd3, 31'd4, 32'hffff_fffb, 31'd6));
        end
        pending_beats.push_back(pack_beat(FUNC_DIV, 32'd7, 31'd3, 32'd0, 31'd5));
        pending_beats.push_back(pack_beat(FUNC_DIV, 32'd0, 31'd3, 32'hffff_fff9, 31'd5));
        pending_beats.push_back(pack_beat(FUNC_ADD, 32'd0, 31'd3, 32'd0, 31'd5));
        pending_beats.push_back(pack_beat(FUNC_ADD, 32'd1, 31'd0, 32'd1, 31'd5));
        pending_beats.push_back(pack_beat(FUNC_MUL, 32'd1, 31'd5, 32'd1, 31'd0));
        pending_beats.push_back(pack_beat(FUNC_INT, 32'd9, 31'd0, 32'd1, 31'd1));
        pending_beats.push_back(pack_beat(FUNC_INT, 32'hffff_fff9, 31'd2, 32'd0, 31'd1));
        pending_beats.push_back(pack_beat(FUNC_INT, 32'h8000_0000, 31'h7fff_ffff, 32'd0, 31'd1));
        pending_beats.push_back(pack_beat(FUNC_MUL, 32'h8000_0000, 31'h7fff_ffff,
                                          32'h8000_0000, 31'h7fff_ffff));
        pending_beats.push_back(pack_beat(FUNC_SUB, 32'h7fff_ffff, 31'h7fff_ffff,
                                          32'h8000_0000, 31'h7fff_fffe));
        pending_beats.push_back(pack_beat(FUNC_DIV, 32'h8000_0000, 31'd1,
                                          32'h8000_0000, 31'h7fff_ffff));
        pending_beats.push_back(pack_beat(FUNC_MUL, 32'd6, 31'd4, 32'd10, 31'd1));
        pending_beats.push_back(pack_beat(FUNC_ADD, 32'd4, 31'd8, 32'd6, 31'd12));
        for (int i = 0; i < 1530; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            pending_beats.push_back(pack_beat(op, rand_num(), rand_den(),
                                              rand_num(), rand_den()));
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_fractions.size() == 0);
        repeat (400) @(posedge aclk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done || cycle_count >= 10_000_000);
        if (!stim_done) begin
            $display("tb: failure");
        end else if (errors == 0 && expected_fractions.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
